/* rtl/ps2mct_pkg.sv */
// ps2mct_pkg: shared widths, codes and types of the PS/2 packet cursor tracker.
// No dependencies; compiled first.
package ps2mct_pkg;

  localparam int POS_BITS_DEF = 12;
  localparam int QUEUE_DEPTH  = 2;

  localparam int BYTE_W     = 8;
  localparam int XY_W       = 12;
  localparam int LIMIT_W    = 12;
  localparam int DELTA_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register map, selected by paddr[REG_IDX_BIT]
  localparam int   REG_IDX_BIT = 2;
  localparam logic REG_X_LIMIT = 1'b0;
  localparam logic REG_Y_LIMIT = 1'b1;

  localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 12'd800;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 12'd600;
  localparam int CUR_X_RST = 400;
  localparam int CUR_Y_RST = 300;

  // first byte bit positions
  localparam int LEFT_BIT  = 0;
  localparam int SYNC_BIT  = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;
  localparam int XOVF_BIT  = 6;
  localparam int YOVF_BIT  = 7;

  // packet_status codes
  localparam logic [STATUS_W-1:0] ST_MOVED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OFFSCREEN = 2'd2;

  // decoded packet handed from front to back
  typedef struct packed {
    logic                      left;
    logic                      ovf;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } pkt_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
  } limits_t;

endpackage

/* rtl/ps2mct_if.sv */
// ps2mct_in_if / ps2mct_out_if: valid/ready channels of the tracker.
// Depends on ps2mct_pkg.
interface ps2mct_in_if;
  logic                          valid;
  logic                          ready;
  logic [ps2mct_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
  modport mon    (input valid, input data_byte, input ready);
endinterface

interface ps2mct_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 left_button;
  logic [ps2mct_pkg::XY_W-1:0]          x_position;
  logic [ps2mct_pkg::XY_W-1:0]          y_position;
  logic signed [ps2mct_pkg::DELTA_W-1:0] last_delta_x;
  logic                                 x_moved_negative;
  logic [ps2mct_pkg::STATUS_W-1:0]      packet_status;

  modport source (output valid, output left_button, output x_position, output y_position,
                  output last_delta_x, output x_moved_negative, output packet_status,
                  input ready);
  modport sink   (input valid, input left_button, input x_position, input y_position,
                  input last_delta_x, input x_moved_negative, input packet_status,
                  output ready);
  modport mon    (input valid, input left_button, input x_position, input y_position,
                  input last_delta_x, input x_moved_negative, input packet_status,
                  input ready);
endinterface

/* rtl/ps2mct_front.sv */
// ps2mct_front: byte framer; syncs on the first byte and emits decoded packets.
// Depends on ps2mct_pkg.
module ps2mct_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ps2mct_pkg::BYTE_W-1:0] in_byte,
  output logic                          pkt_push,
  output ps2mct_pkg::pkt_t              pkt,
  input  logic                          q_full
);
  import ps2mct_pkg::*;

  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_THIRD  = 2'd2;

  logic [1:0]        idx_r, idx_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic [BYTE_W-1:0] second_r, second_nxt;
  logic              acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    pkt_push   = 1'b0;
    if (acc) begin
      unique case (idx_r)
        IDX_SECOND: begin
          second_nxt = in_byte;
          idx_nxt    = IDX_THIRD;
        end
        IDX_THIRD: begin
          idx_nxt  = IDX_FIRST;
          pkt_push = 1'b1;
        end
        default: begin
          // unreachable code 3 behaves as the first-byte slot
          if (in_byte[SYNC_BIT]) begin
            first_nxt = in_byte;
            idx_nxt   = IDX_SECOND;
          end else begin
            idx_nxt = IDX_FIRST;
          end
        end
      endcase
    end
  end

  always_comb begin
    pkt.left = first_r[LEFT_BIT];
    pkt.ovf  = first_r[XOVF_BIT] | first_r[YOVF_BIT];
    pkt.dx   = {first_r[XSIGN_BIT], second_r};
    pkt.dy   = {first_r[YSIGN_BIT], in_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= IDX_FIRST;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      idx_r    <= idx_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

/* rtl/ps2mct_queue.sv */
// ps2mct_queue: small packet FIFO between framer and cursor stage.
// Depends on ps2mct_pkg.
module ps2mct_queue #(
  parameter int DEPTH = ps2mct_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ps2mct_pkg::pkt_t push_data,
  output logic             full,
  input  logic             pop,
  output ps2mct_pkg::pkt_t pop_data,
  output logic             not_empty
);
  import ps2mct_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pkt_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/ps2mct_back.sv */
// ps2mct_back: cursor update, bounds check and result register.
// Depends on ps2mct_pkg.
module ps2mct_back #(
  parameter int POSITION_BITS = ps2mct_pkg::POS_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  ps2mct_pkg::pkt_t                      q_pkt,
  output logic                                  q_pop,
  input  ps2mct_pkg::limits_t                   lim,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  left_button,
  output logic [ps2mct_pkg::XY_W-1:0]           x_position,
  output logic [ps2mct_pkg::XY_W-1:0]           y_position,
  output logic signed [ps2mct_pkg::DELTA_W-1:0] last_delta_x,
  output logic                                  x_moved_negative,
  output logic [ps2mct_pkg::STATUS_W-1:0]       packet_status
);
  import ps2mct_pkg::*;

  // room for sign plus a carry over the wider of cursor and limit
  localparam int CALC_W = ((POSITION_BITS > LIMIT_W) ? POSITION_BITS : LIMIT_W) + 2;
  localparam logic [CALC_W-1:0] POS_MAX = CALC_W'((1 << POSITION_BITS) - 1);

  logic [POSITION_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [POSITION_BITS-1:0] cur_y_r, cur_y_nxt;
  logic signed [DELTA_W-1:0] dx_r, dx_nxt;

  logic                      out_valid_r;
  logic                      out_left_r;
  logic [XY_W-1:0]           out_x_r, out_y_r;
  logic signed [DELTA_W-1:0] out_dx_r;
  logic [STATUS_W-1:0]       out_st_r, st_nxt;

  logic [CALC_W-1:0] nx, ny, xlim, ylim, x_ext, y_ext;
  logic              x_in, y_in;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    nx   = CALC_W'(cur_x_r) + {{(CALC_W-DELTA_W){q_pkt.dx[DELTA_W-1]}}, q_pkt.dx};
    ny   = CALC_W'(cur_y_r) - {{(CALC_W-DELTA_W){q_pkt.dy[DELTA_W-1]}}, q_pkt.dy};
    xlim = (CALC_W'(lim.x_limit) > POS_MAX) ? POS_MAX : CALC_W'(lim.x_limit);
    ylim = (CALC_W'(lim.y_limit) > POS_MAX) ? POS_MAX : CALC_W'(lim.y_limit);
    x_in = !nx[CALC_W-1] && (nx <= xlim);
    y_in = !ny[CALC_W-1] && (ny <= ylim);

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    dx_nxt    = dx_r;
    if (q_pkt.ovf) begin
      st_nxt = ST_OVERFLOW;
    end else begin
      dx_nxt = q_pkt.dx;
      if (x_in && y_in) begin
        cur_x_nxt = nx[POSITION_BITS-1:0];
        cur_y_nxt = ny[POSITION_BITS-1:0];
        st_nxt    = ST_MOVED;
      end else begin
        st_nxt = ST_OFFSCREEN;
      end
    end
    x_ext = CALC_W'(cur_x_nxt);
    y_ext = CALC_W'(cur_y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= POSITION_BITS'(CUR_X_RST);
      cur_y_r     <= POSITION_BITS'(CUR_Y_RST);
      dx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_x_r     <= cur_x_nxt;
        cur_y_r     <= cur_y_nxt;
        dx_r        <= dx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_left_r <= q_pkt.left;
      out_x_r    <= x_ext[XY_W-1:0];
      out_y_r    <= y_ext[XY_W-1:0];
      out_dx_r   <= dx_nxt;
      out_st_r   <= st_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign left_button      = out_left_r;
  assign x_position       = out_x_r;
  assign y_position       = out_y_r;
  assign last_delta_x     = out_dx_r;
  assign x_moved_negative = out_dx_r[DELTA_W-1];
  assign packet_status    = out_st_r;

endmodule

/* rtl/ps2_mouse_packet_cursor_tracker_core.sv */
// PS/2 mouse packet cursor tracker: one raw mouse byte is taken per beat on
// in_if; a packet starts on a byte with bit 3 set, other bytes at that point
// are skipped. Each third byte yields exactly one result beat on out_if with
// the left button, the cursor position, the last valid dX and a status code
// (moved, dropped for X/Y overflow, or rejected as off screen; bounds are
// inclusive 0..x_limit and 0..y_limit). The input sustains one byte per clock
// while the queue has room; a result passes through the packet queue entry it
// is decoded into, then the result register it is popped into. The two-entry
// queue fills only while the result side stalls, which lowers in_if.ready.
// x_limit sits at byte address 0 and y_limit at 4 (paddr bit 2 selects; low
// bits ignored), 12 bits each, written by the user only while the block is
// idle; the block itself does not enforce this.
// Depends on ps2mct_pkg, ps2mct_if, ps2mct_front, ps2mct_queue, ps2mct_back.
module ps2_mouse_packet_cursor_tracker_core #(
  parameter int POSITION_BITS = ps2mct_pkg::POS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ps2mct_in_if.sink                         in_if,
  ps2mct_out_if.source                      out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ps2mct_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ps2mct_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ps2mct_pkg::CFG_DATA_W-1:0] prdata,
  output logic                              pready
);
  import ps2mct_pkg::*;

  // configuration registers
  logic [LIMIT_W-1:0] x_limit_r, x_limit_nxt;
  logic [LIMIT_W-1:0] y_limit_r, y_limit_nxt;
  logic               cfg_wr;
  limits_t            lim;

  // front -> queue -> back
  logic pkt_push, q_full, q_pop, q_valid;
  pkt_t pkt_in, pkt_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    x_limit_nxt = x_limit_r;
    y_limit_nxt = y_limit_r;
    if (cfg_wr) begin
      unique case (paddr[REG_IDX_BIT])
        REG_X_LIMIT: x_limit_nxt = pwdata[LIMIT_W-1:0];
        REG_Y_LIMIT: y_limit_nxt = pwdata[LIMIT_W-1:0];
        default:     x_limit_nxt = x_limit_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_BIT])
      REG_X_LIMIT: prdata = CFG_DATA_W'(x_limit_r);
      REG_Y_LIMIT: prdata = CFG_DATA_W'(y_limit_r);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
    end else begin
      x_limit_r <= x_limit_nxt;
      y_limit_r <= y_limit_nxt;
    end
  end

  assign lim.x_limit = x_limit_r;
  assign lim.y_limit = y_limit_r;

  // framer: counts bytes and decodes the packet on its third beat
  ps2mct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_byte  (in_if.data_byte),
    .pkt_push (pkt_push),
    .pkt      (pkt_in),
    .q_full   (q_full)
  );

  // decouples the framer from a stalled result side
  ps2mct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pkt_push),
    .push_data (pkt_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pkt_out),
    .not_empty (q_valid)
  );

  // cursor state and the result register
  ps2mct_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pkt            (pkt_out),
    .q_pop            (q_pop),
    .lim              (lim),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .left_button      (out_if.left_button),
    .x_position       (out_if.x_position),
    .y_position       (out_if.y_position),
    .last_delta_x     (out_if.last_delta_x),
    .x_moved_negative (out_if.x_moved_negative),
    .packet_status    (out_if.packet_status)
  );

endmodule

/* rtl/ps2mct_checker.sv */
// ps2mct_checker: port-level checks on the tracker's result channel.
// Depends on ps2mct_pkg; bound to the top level below.
module ps2mct_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [ps2mct_pkg::XY_W-1:0]           out_x_position,
  input logic [ps2mct_pkg::XY_W-1:0]           out_y_position,
  input logic signed [ps2mct_pkg::DELTA_W-1:0] out_last_delta_x,
  input logic                                  out_x_moved_negative,
  input logic [ps2mct_pkg::STATUS_W-1:0]       out_packet_status
);
  import ps2mct_pkg::*;

  // a stalled result beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_x_position) && $stable(out_y_position) &&
      $stable(out_packet_status))
    else $error("result payload changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_packet_status == ST_MOVED ||
                   out_packet_status == ST_OVERFLOW ||
                   out_packet_status == ST_OFFSCREEN))
    else $error("undefined packet status");

  a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x_moved_negative == out_last_delta_x[DELTA_W-1])
    else $error("x sign flag disagrees with stored dX");

  // nothing is offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind ps2_mouse_packet_cursor_tracker_core ps2mct_checker u_ps2mct_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_if.valid),
  .out_ready            (out_if.ready),
  .out_x_position       (out_if.x_position),
  .out_y_position       (out_if.y_position),
  .out_last_delta_x     (out_if.last_delta_x),
  .out_x_moved_negative (out_if.x_moved_negative),
  .out_packet_status    (out_if.packet_status)
);

/* bench/ps2mct_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard of the PS/2 packet cursor tracker bench: packet framing and cursor prediction.
// Depends on ps2mct_pkg.
package ps2mct_tb_pkg;
  import ps2mct_pkg::*;

  typedef struct packed {
    logic                      left;
    logic [XY_W-1:0]           x;
    logic [XY_W-1:0]           y;
    logic signed [DELTA_W-1:0] dx;
    logic                      xneg;
    logic [STATUS_W-1:0]       status;
  } cursor_result_t;

  class cursor_scoreboard;
    int unsigned               errors;
    logic [1:0]                frame_pos;
    logic [BYTE_W-1:0]         head_byte;
    logic [BYTE_W-1:0]         dx_byte;
    logic [XY_W-1:0]           cur_x;
    logic [XY_W-1:0]           cur_y;
    logic                      left;
    logic signed [DELTA_W-1:0] last_dx;
    logic                      last_xneg;
    logic [LIMIT_W-1:0]        x_lim;
    logic [LIMIT_W-1:0]        y_lim;
    cursor_result_t            expected_q[$];

    function new();
      errors    = 0;
      frame_pos = 2'd0;
      head_byte = '0;
      dx_byte   = '0;
      cur_x     = XY_W'(CUR_X_RST);
      cur_y     = XY_W'(CUR_Y_RST);
      left      = 1'b0;
      last_dx   = '0;
      last_xneg = 1'b0;
      x_lim     = X_LIMIT_RST;
      y_lim     = Y_LIMIT_RST;
    endfunction

    function void set_limit(logic idx, logic [LIMIT_W-1:0] value);
      if (idx == REG_X_LIMIT) x_lim = value;
      else y_lim = value;
    endfunction

    function logic [LIMIT_W-1:0] limit(logic idx);
      return (idx == REG_X_LIMIT) ? x_lim : y_lim;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted mouse byte; the third byte of a packet queues one result
    function void note_byte(logic [BYTE_W-1:0] b);
      cursor_result_t            r;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      int                        nx;
      int                        ny;
      case (frame_pos)
        2'd1: begin
          dx_byte   = b;
          frame_pos = 2'd2;
        end
        2'd2: begin
          frame_pos = 2'd0;
          left      = head_byte[LEFT_BIT];
          if (head_byte[XOVF_BIT] || head_byte[YOVF_BIT]) begin
            r.status = ST_OVERFLOW;
          end else begin
            dx        = {head_byte[XSIGN_BIT], dx_byte};
            dy        = {head_byte[YSIGN_BIT], b};
            nx        = int'(cur_x) + int'(dx);
            ny        = int'(cur_y) - int'(dy);
            last_dx   = dx;
            last_xneg = head_byte[XSIGN_BIT];
            if (nx >= 0 && nx <= int'(x_lim) && ny >= 0 && ny <= int'(y_lim)) begin
              cur_x    = XY_W'(nx);
              cur_y    = XY_W'(ny);
              r.status = ST_MOVED;
            end else begin
              r.status = ST_OFFSCREEN;
            end
          end
          r.left = left;
          r.x    = cur_x;
          r.y    = cur_y;
          r.dx   = last_dx;
          r.xneg = last_xneg;
          expected_q.push_back(r);
        end
        default: begin
          if (b[SYNC_BIT]) begin
            head_byte = b;
            frame_pos = 2'd1;
          end else begin
            frame_pos = 2'd0;
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(cursor_result_t got);
      cursor_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat with none expected (x=%0d y=%0d)", got.x, got.y));
        return;
      end
      want = expected_q.pop_front();
      if (got.left !== want.left)
        report($sformatf("left_button %b, want %b", got.left, want.left));
      if (got.x !== want.x)
        report($sformatf("x_position %0d, want %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("y_position %0d, want %0d", got.y, want.y));
      if (got.dx !== want.dx)
        report($sformatf("last_delta_x %0d, want %0d", got.dx, want.dx));
      if (got.xneg !== want.xneg)
        report($sformatf("x_moved_negative %b, want %b", got.xneg, want.xneg));
      if (got.status !== want.status)
        report($sformatf("packet_status %0d, want %0d", got.status, want.status));
    endtask
  endclass

endpackage

/* bench/tb_ps2_mouse_packet_cursor_tracker_core.sv */
`timescale 1ns / 1ps
// Top of the PS/2 packet cursor tracker bench: clock, reset, byte and result drivers, APB access.
// Depends on ps2mct_pkg, ps2mct_if, ps2mct_tb_pkg and the tracker core.
module tb_ps2_mouse_packet_cursor_tracker_core;
  import ps2mct_pkg::*;
  import ps2mct_tb_pkg::*;

  typedef enum int {DRIFT_NONE, DRIFT_RIGHT_DOWN, DRIFT_LEFT_UP} drift_t;

  localparam int N_PHASES     = 9;
  localparam int PHASE_BYTES  = 183;   // packet bytes per random phase
  localparam int RANDOM_LIMIT = -1;
  localparam int SETTLE       = 8;     // cycles past the last result before a register write

  // limits per random phase; RANDOM_LIMIT draws a fresh value
  localparam int PHASE_XL[N_PHASES] = '{4095, 0, 100, 4095, 0, RANDOM_LIMIT, RANDOM_LIMIT,
                                        800, RANDOM_LIMIT};
  localparam int PHASE_YL[N_PHASES] = '{4095, 0, 50, 0, 4095, RANDOM_LIMIT, RANDOM_LIMIT,
                                        600, RANDOM_LIMIT};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bit idle_on = 1'b1;   // both sides draw random waits while set

  cursor_scoreboard sb;

  ps2mct_in_if  in_bus ();
  ps2mct_out_if out_bus ();

  ps2_mouse_packet_cursor_tracker_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor: both channels sampled at the rising edge, before the block's own
  // flops move. A byte beat feeds the predictor, a result beat is checked.
  always @(posedge clk) begin
    cursor_result_t got;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_byte(in_bus.data_byte);
      if (out_bus.valid === 1'b1 && out_bus.ready) begin
        got.left   = out_bus.left_button;
        got.x      = out_bus.x_position;
        got.y      = out_bus.y_position;
        got.dx     = out_bus.last_delta_x;
        got.xneg   = out_bus.x_moved_negative;
        got.status = out_bus.packet_status;
        sb.check_result(got);
      end
    end
  end

  // Result side: a random stall ahead of every beat while idle_on is set, ready
  // then held until the beat goes through.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid === 1'b1 && rst_n));
    end
  end

  // Present one byte after a random gap. Valid is left high on return so a
  // back-to-back byte never sees valid dropped and raised in the same step.
  task send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  // drop valid once the last beat has been taken
  task hold_input();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task wait_drained();
    hold_input();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // APB read of one limit register, compared with the predictor's copy
  task cfg_readback(input logic idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(idx) << REG_IDX_BIT;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== CFG_DATA_W'(sb.limit(idx)))
      sb.report($sformatf("register %0d reads %0d, want %0d", idx, prdata, sb.limit(idx)));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // APB write; the bits above the 12-bit field carry noise and must be masked
  task cfg_write(input logic idx, input logic [LIMIT_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word            = $urandom;
    word[LIMIT_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << REG_IDX_BIT;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_limit(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_readback(idx);
  endtask

  // Random phase: mostly well-formed packets with random content, plus lone
  // noise bytes and truncated packets. The cursor drifts one way in some
  // phases so it reaches the screen edges; small deltas land on them exactly.
  task run_phase(input int n_bytes);
    drift_t            drift;
    int                sent;
    int                r;
    int                fill;
    bit                paused;
    bit                realign;
    logic [BYTE_W-1:0] head;
    logic [BYTE_W-1:0] dxb;
    logic [BYTE_W-1:0] dyb;
    drift   = drift_t'($urandom_range(0, 2));
    sent    = 0;
    paused  = 1'b0;
    realign = 1'b0;
    while (sent < n_bytes) begin
      // halfway: stop sending until every result is out
      if (!paused && sent >= n_bytes / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 82) begin
        if (realign) begin
          // finish whatever packet noise left open so this one frames cleanly
          hold_input();
          fill = (sb.frame_pos == 2'd0) ? 0 : 3 - sb.frame_pos;
          repeat (fill) send_byte(BYTE_W'($urandom));
          sent += fill;
          realign = 1'b0;
        end
        head            = $urandom;
        head[SYNC_BIT]  = 1'b1;
        head[XOVF_BIT]  = ($urandom_range(0, 9) == 0);
        head[YOVF_BIT]  = ($urandom_range(0, 9) == 0);
        case (drift)
          DRIFT_RIGHT_DOWN: begin
            head[XSIGN_BIT] = 1'b0;
            head[YSIGN_BIT] = 1'b1;
          end
          DRIFT_LEFT_UP: begin
            head[XSIGN_BIT] = 1'b1;
            head[YSIGN_BIT] = 1'b0;
          end
          default: ;
        endcase
        dxb = $urandom;
        dyb = $urandom;
        if ($urandom_range(0, 2) == 0) begin
          dxb = head[XSIGN_BIT] ? 8'hFF - BYTE_W'($urandom_range(0, 3))
                                : BYTE_W'($urandom_range(0, 3));
          dyb = head[YSIGN_BIT] ? 8'hFF - BYTE_W'($urandom_range(0, 3))
                                : BYTE_W'($urandom_range(0, 3));
        end
        send_byte(head);
        send_byte(dxb);
        send_byte(dyb);
        sent += 3;
      end else if (r < 92) begin
        send_byte(BYTE_W'($urandom));
        sent += 1;
        realign = 1'b1;
      end else begin
        // truncated packet: sync byte and at most one more
        head           = $urandom;
        head[SYNC_BIT] = 1'b1;
        send_byte(head);
        sent += 1;
        if ($urandom_range(0, 1)) begin
          send_byte(BYTE_W'($urandom));
          sent += 1;
        end
        realign = 1'b1;
      end
    end
  endtask

  initial begin
    int                 xl;
    int                 yl;
    logic [BYTE_W-1:0]  directed[$];
    sb               = new();
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of both limits
    cfg_readback(REG_X_LIMIT);
    cfg_readback(REG_Y_LIMIT);

    // Directed part under the reset limits: unsynchronised bytes, a null
    // move, full positive and negative deltas, left button, each overflow
    // flag alone and together, and moves pushed off the screen.
    directed = '{8'h00, 8'hF7,
                 8'h08, 8'h00, 8'h00,
                 8'h09, 8'hFF, 8'h01,
                 8'h18, 8'h00, 8'h00,
                 8'h28, 8'h7F, 8'h00,
                 8'h4B, 8'h12, 8'h34,
                 8'h88, 8'h56, 8'h78,
                 8'hFF, 8'hFF, 8'hFF,
                 8'h28, 8'h00, 8'h00,
                 8'h38, 8'h01, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);

    for (int p = 0; p < N_PHASES; p++) begin
      // registers only change with the block idle
      wait_drained();
      repeat (SETTLE) @(posedge clk);
      xl = (PHASE_XL[p] == RANDOM_LIMIT) ? $urandom_range(0, 4095) : PHASE_XL[p];
      yl = (PHASE_YL[p] == RANDOM_LIMIT) ? $urandom_range(0, 4095) : PHASE_YL[p];
      cfg_write(REG_X_LIMIT, LIMIT_W'(xl));
      cfg_write(REG_Y_LIMIT, LIMIT_W'(yl));
      idle_on = (p % 3 != 2);   // every third phase runs flat out
      run_phase(PHASE_BYTES);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ps2_mouse_packet_cursor_tracker_core] OK");
    end else begin
      $display("[ps2_mouse_packet_cursor_tracker_core] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[ps2_mouse_packet_cursor_tracker_core] ERROR");
    $finish;
  end

endmodule
